// ===== rtl/core/cec_pkg.sv =====
// Shared constants, codes and types for the edge classifier.
package cec_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 36;
    localparam int GRAY_W        = 8;
    localparam int BLUR_W        = 16;
    localparam int GRAD_W        = 19;
    localparam int ABS_W         = 18;
    localparam int MAG_W         = 36;
    localparam int SEC_W         = 2;
    localparam int CLS_W         = 2;
    localparam int POS_W         = 19;
    localparam int ROW_W         = 17;

    localparam logic [11:0] WIDTH_RST  = 12'd1920;
    localparam logic [15:0] HEIGHT_RST = 16'd1080;
    localparam logic [MAG_W-1:0] LOW_RST  = 36'd16438970;
    localparam logic [MAG_W-1:0] HIGH_RST = 36'd147950732;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_LOW    = 2'd2,
        CFG_HIGH   = 2'd3
    } t_cfg_idx;

    typedef enum logic [SEC_W-1:0] {
        SEC_HORZ = 2'd0,
        SEC_DIAG_UP = 2'd1,
        SEC_VERT = 2'd2,
        SEC_DIAG_DN = 2'd3
    } t_sector;

    typedef enum logic [CLS_W-1:0] {
        CLS_NONE   = 2'd0,
        CLS_WEAK   = 2'd1,
        CLS_STRONG = 2'd2
    } t_class;

    typedef struct packed {
        logic bmask;
        logic smask;
        logic nmask;
        logic emit;
        logic last;
    } t_flags;

endpackage

// ===== rtl/core/cec_pix_if.sv =====
// Input pixel channel.
interface cec_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       flush;

    modport source (output valid, red, green, blue, flush, input ready);
    modport sink   (input valid, red, green, blue, flush, output ready);
endinterface

// ===== rtl/core/cec_res_if.sv =====
// Output classification channel.
interface cec_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] edge_class;
    logic       frame_end;

    modport source (output valid, edge_class, frame_end, input ready);
    modport sink   (input valid, edge_class, frame_end, output ready);
endinterface

// ===== rtl/core/cec_ram.sv =====
// Generic simple dual-port RAM with registered read.
module cec_ram #(
    parameter int W = 8,
    parameter int D = 2048
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/cec_gauss.sv =====
// Gray line store and 5x5 Gaussian as weighted column sums.
module cec_gauss #(
    parameter int MAX_WIDTH = cec_pkg::MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic                         i_rd,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    input  logic                         i_vld1,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr1,
    input  logic [cec_pkg::GRAY_W-1:0]   i_gray1,
    input  logic                         i_bmask2,
    output logic [cec_pkg::BLUR_W-1:0]   o_blur3
);
    import cec_pkg::*;

    localparam int LW = 4 * GRAY_W;
    localparam int SW = 14;

    logic [LW-1:0]     rdata;
    logic [SW-1:0]     col_a, col_b, col_c;
    logic [SW-1:0]     r_ha [0:4];
    logic [SW-1:0]     r_hb [1:4];
    logic [SW-1:0]     r_hc [2:4];
    logic [BLUR_W-1:0] sum;
    logic [BLUR_W-1:0] r_blur;
    logic [SW-1:0]     v0, v1, v2, v3, v4;

    cec_ram #(.W(LW), .D(MAX_WIDTH)) u_gray_ram (
        .i_clk  (i_clk),
        .i_we   (i_en && i_vld1),
        .i_waddr(i_wr_addr1),
        .i_wdata({rdata[LW-GRAY_W-1:0], i_gray1}),
        .i_re   (i_rd),
        .i_raddr(i_rd_addr),
        .o_rdata(rdata)
    );

    always_comb begin
        v0 = SW'(rdata[31:24]);
        v1 = SW'(rdata[23:16]);
        v2 = SW'(rdata[15:8]);
        v3 = SW'(rdata[7:0]);
        v4 = SW'(i_gray1);
        col_a = SW'(2 * (v0 + v4) + 4 * (v1 + v3) + 5 * v2);
        col_b = SW'(4 * (v0 + v4) + 9 * (v1 + v3) + 12 * v2);
        col_c = SW'(5 * (v0 + v4) + 12 * (v1 + v3) + 15 * v2);
        sum = BLUR_W'(r_ha[0]) + BLUR_W'(r_hb[1]) + BLUR_W'(r_hc[2])
            + BLUR_W'(r_hb[3]) + BLUR_W'(r_ha[4]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_vld1) begin
            for (int i = 0; i < 4; i++) r_ha[i] <= r_ha[i+1];
            for (int i = 1; i < 4; i++) r_hb[i] <= r_hb[i+1];
            for (int i = 2; i < 4; i++) r_hc[i] <= r_hc[i+1];
            r_ha[4] <= col_a;
            r_hb[4] <= col_b;
            r_hc[4] <= col_c;
        end
        if (i_en) begin
            r_blur <= i_bmask2 ? sum : '0;
        end
    end

    assign o_blur3 = r_blur;
endmodule

// ===== rtl/core/cec_sobel.sv =====
// Blur line store, Sobel gradients, squared magnitude and direction sector.
module cec_sobel #(
    parameter int MAX_WIDTH = cec_pkg::MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic                         i_vld2,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_addr2,
    input  logic                         i_vld3,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_addr3,
    input  logic [cec_pkg::BLUR_W-1:0]   i_blur3,
    input  logic                         i_smask7,
    output logic [cec_pkg::MAG_W-1:0]    o_mag7,
    output logic [cec_pkg::SEC_W-1:0]    o_sec7
);
    import cec_pkg::*;

    localparam int LW = 2 * BLUR_W;

    logic [LW-1:0]            rdata;
    logic [BLUR_W-1:0]        r_win [0:2][0:2];
    logic signed [GRAD_W-1:0] b [0:2][0:2];
    logic signed [GRAD_W-1:0] gx, gy, r_gx, r_gy;
    logic [ABS_W-1:0]         ax, ay, r_ax, r_ay, r_dif;
    logic [ABS_W:0]           r_sum;
    logic                     r_ayz5, r_aygt5, r_gxpos5;
    logic                     r_ayz6, r_aygt6, r_gxpos6;
    logic [MAG_W-1:0]         r_ax2, r_ay2, r_sm2;
    logic [MAG_W+1:0]         r_sp2;
    logic [MAG_W:0]           two;
    t_sector                  sec;

    cec_ram #(.W(LW), .D(MAX_WIDTH)) u_blur_ram (
        .i_clk  (i_clk),
        .i_we   (i_en && i_vld3),
        .i_waddr(i_addr3),
        .i_wdata({rdata[BLUR_W-1:0], i_blur3}),
        .i_re   (i_en && i_vld2),
        .i_raddr(i_addr2),
        .o_rdata(rdata)
    );

    always_comb begin
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++)
                b[c][r] = GRAD_W'(r_win[c][r]);
        gx = GRAD_W'((b[2][0] - b[0][0]) + 2 * (b[2][1] - b[0][1]) + (b[2][2] - b[0][2]));
        gy = GRAD_W'((b[0][2] - b[0][0]) + 2 * (b[1][2] - b[1][0]) + (b[2][2] - b[2][0]));
        ax = r_gx[GRAD_W-1] ? ABS_W'(-r_gx) : ABS_W'(r_gx);
        ay = r_gy[GRAD_W-1] ? ABS_W'(-r_gy) : ABS_W'(r_gy);
        two = {r_ax2, 1'b0};
        if (r_ayz6 || r_sp2 < (MAG_W+2)'(two)) begin
            sec = SEC_HORZ;
        end else if (r_aygt6 && (MAG_W+1)'(r_sm2) > two) begin
            sec = SEC_VERT;
        end else begin
            sec = r_gxpos6 ? SEC_DIAG_UP : SEC_DIAG_DN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_vld3) begin
            for (int r = 0; r < 3; r++) begin
                r_win[0][r] <= r_win[1][r];
                r_win[1][r] <= r_win[2][r];
            end
            r_win[2][0] <= rdata[LW-1:BLUR_W];
            r_win[2][1] <= rdata[BLUR_W-1:0];
            r_win[2][2] <= i_blur3;
        end
        if (i_en) begin
            r_gx     <= gx;
            r_gy     <= gy;
            r_ax     <= ax;
            r_ay     <= ay;
            r_sum    <= (ABS_W+1)'(ax) + (ABS_W+1)'(ay);
            r_dif    <= ay - ax;
            r_ayz5   <= (r_gy == '0);
            r_aygt5  <= (ay > ax);
            r_gxpos5 <= r_gy[GRAD_W-1] ? r_gx[GRAD_W-1] : (r_gx > 0);
            r_ax2    <= r_ax * r_ax;
            r_ay2    <= r_ay * r_ay;
            r_sp2    <= r_sum * r_sum;
            r_sm2    <= r_dif * r_dif;
            r_ayz6   <= r_ayz5;
            r_aygt6  <= r_aygt5;
            r_gxpos6 <= r_gxpos5;
        end
    end

    assign o_mag7 = i_smask7 ? r_ax2 + r_ay2 : '0;
    assign o_sec7 = i_smask7 ? sec : SEC_HORZ;
endmodule

// ===== rtl/core/cec_nms.sv =====
// Magnitude line store, non-maximum suppression and threshold classing.
module cec_nms #(
    parameter int MAX_WIDTH = cec_pkg::MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic                         i_vld6,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_addr6,
    input  logic                         i_vld7,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_addr7,
    input  logic [cec_pkg::MAG_W-1:0]    i_mag7,
    input  logic [cec_pkg::SEC_W-1:0]    i_sec7,
    input  logic                         i_nmask8,
    input  logic [cec_pkg::MAG_W-1:0]    i_low,
    input  logic [cec_pkg::MAG_W-1:0]    i_high,
    output logic [cec_pkg::CLS_W-1:0]    o_cls9
);
    import cec_pkg::*;

    localparam int LW = 2 * MAG_W + SEC_W;

    logic [LW-1:0]    rdata;
    logic [MAG_W-1:0] r_mw [0:2][0:2];
    logic [SEC_W-1:0] r_ws [0:2];
    logic [MAG_W-1:0] mc, m1, m2, r_kept;

    cec_ram #(.W(LW), .D(MAX_WIDTH)) u_mag_ram (
        .i_clk  (i_clk),
        .i_we   (i_en && i_vld7),
        .i_waddr(i_addr7),
        .i_wdata({rdata[MAG_W+SEC_W-1:SEC_W], i_mag7, i_sec7}),
        .i_re   (i_en && i_vld6),
        .i_raddr(i_addr6),
        .o_rdata(rdata)
    );

    always_comb begin
        mc = r_mw[1][1];
        case (t_sector'(r_ws[1]))
            SEC_HORZ:    begin m1 = r_mw[0][1]; m2 = r_mw[2][1]; end
            SEC_DIAG_UP: begin m1 = r_mw[2][0]; m2 = r_mw[0][2]; end
            SEC_VERT:    begin m1 = r_mw[1][0]; m2 = r_mw[1][2]; end
            default:     begin m1 = r_mw[0][0]; m2 = r_mw[2][2]; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_vld7) begin
            for (int r = 0; r < 3; r++) begin
                r_mw[0][r] <= r_mw[1][r];
                r_mw[1][r] <= r_mw[2][r];
            end
            r_ws[0] <= r_ws[1];
            r_ws[1] <= r_ws[2];
            r_mw[2][0] <= rdata[LW-1:MAG_W+SEC_W];
            r_mw[2][1] <= rdata[MAG_W+SEC_W-1:SEC_W];
            r_mw[2][2] <= i_mag7;
            r_ws[2]    <= rdata[SEC_W-1:0];
        end
        if (i_en) begin
            r_kept <= (i_nmask8 && mc >= m1 && mc >= m2) ? mc : '0;
        end
    end

    assign o_cls9 = (r_kept >= i_high) ? CLS_STRONG :
                    (r_kept >= i_low)  ? CLS_WEAK : CLS_NONE;
endmodule

// ===== rtl/core/canny_edge_classifier.sv =====
// Top level: position tracking, configuration, stage control and output register.
//
// Streaming Canny edge classifier without hysteresis. It takes one RGB word per
// clock unless the output stalls, and gives one class word per frame pixel; the
// class of pixel e comes out with input word e+4*width+4, so 4*width+4 flush
// words after a frame drain it. Each word spends nine pipeline stages inside; the
// rate of one word per cycle is set by three line memories of MAX_WIDTH entries
// (gray, blur, magnitude), each read and written once per word at a column
// address. The output register decouples the two sides; a stalled output holds
// the whole pipeline. No clearing pass: stale line entries only reach masked borders.
// Width and height writes restart the frame; write configuration only when idle.
module canny_edge_classifier #(
    parameter int MAX_WIDTH = cec_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cec_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cec_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cec_pix_if.sink                        i_pix,
    cec_res_if.source                      o_res
);
    import cec_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (WW > 12) ? WW : 12;
    localparam int NS = 9;

    logic [11:0]      r_width;
    logic [15:0]      r_height;
    logic [MAG_W-1:0] r_low, r_high;
    logic [CW-1:0]    w_ext;
    logic [WW-1:0]    weff;
    logic [15:0]      heff;

    logic [AW-1:0]    r_cx;
    logic [ROW_W-1:0] r_cy;
    logic signed [POS_W-1:0] xs [2:4];
    logic signed [POS_W-1:0] ys [2:4];
    logic signed [POS_W-1:0] w_s, h_s, cx_s, cy_s;
    logic             wrap;
    t_flags           flags;
    logic             en, accept;
    logic [15:0]      gray_sum;
    logic [GRAY_W-1:0] gray;

    logic [NS:1]      r_vld;
    t_flags           r_tag [1:NS];
    logic [AW-1:0]    r_cx1;
    logic [GRAY_W-1:0] r_gray1;
    logic [AW-1:0]    r_xa2 [1:3];
    logic [AW-1:0]    r_xa3 [1:7];

    logic [BLUR_W-1:0] blur3;
    logic [MAG_W-1:0]  mag7;
    logic [SEC_W-1:0]  sec7;
    logic [CLS_W-1:0]  cls9;

    logic              r_ovld;
    logic [CLS_W-1:0]  r_ocls;
    logic              r_olast;

    always_comb begin
        w_ext = CW'(r_width);
        if (w_ext < CW'(5)) begin
            weff = WW'(5);
        end else if (w_ext > CW'(MAX_WIDTH)) begin
            weff = WW'(MAX_WIDTH);
        end else begin
            weff = WW'(w_ext);
        end
        heff = (r_height < 16'd5) ? 16'd5 : r_height;

        w_s  = POS_W'(weff);
        h_s  = POS_W'(heff);
        cx_s = POS_W'(r_cx);
        cy_s = POS_W'(r_cy);
        for (int k = 2; k <= 4; k++) begin
            wrap  = (cx_s < POS_W'(k));
            xs[k] = wrap ? cx_s + w_s - POS_W'(k) : cx_s - POS_W'(k);
            ys[k] = cy_s - POS_W'(k) - (wrap ? POS_W'(1) : POS_W'(0));
        end
        flags.bmask = xs[2] >= 2 && xs[2] <= w_s - 3 && ys[2] >= 2 && ys[2] <= h_s - 3;
        flags.smask = xs[3] >= 1 && xs[3] <= w_s - 2 && ys[3] >= 1 && ys[3] <= h_s - 2;
        flags.nmask = xs[4] >= 1 && xs[4] <= w_s - 2 && ys[4] >= 1 && ys[4] <= h_s - 2;
        flags.emit  = ys[4] >= 0 && ys[4] < h_s;
        flags.last  = flags.emit && xs[4] == w_s - 1 && ys[4] == h_s - 1;

        gray_sum = 16'd77 * 16'(i_pix.red) + 16'd150 * 16'(i_pix.green)
                 + 16'd29 * 16'(i_pix.blue) + 16'd128;
        gray = i_pix.flush ? '0 : gray_sum[15:8];
    end

    assign en          = !r_ovld || o_res.ready;
    assign accept      = i_pix.valid && en;
    assign i_pix.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_low    <= LOW_RST;
            r_high   <= HIGH_RST;
            r_cx     <= '0;
            r_cy     <= '0;
            r_vld    <= '0;
            r_ovld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_WIDTH:  r_width  <= i_cfg_data[11:0];
                    CFG_HEIGHT: r_height <= i_cfg_data[15:0];
                    CFG_LOW:    r_low    <= i_cfg_data;
                    default:    r_high   <= i_cfg_data;
                endcase
            end
            if (i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_WIDTH ||
                             t_cfg_idx'(i_cfg_idx) == CFG_HEIGHT)) begin
                r_cx <= '0;
                r_cy <= '0;
            end else if (accept) begin
                if (flags.last) begin
                    r_cx <= '0;
                    r_cy <= '0;
                end else if (WW'(r_cx) + WW'(1) >= weff) begin
                    r_cx <= '0;
                    r_cy <= r_cy + ROW_W'(1);
                end else begin
                    r_cx <= r_cx + AW'(1);
                end
            end
            if (en) begin
                r_vld  <= {r_vld[NS-1:1], accept};
                r_ovld <= r_vld[NS] && r_tag[NS].emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag[1] <= flags;
            for (int i = 2; i <= NS; i++) r_tag[i] <= r_tag[i-1];
            r_cx1    <= r_cx;
            r_gray1  <= gray;
            r_xa2[1] <= xs[2][AW-1:0];
            for (int i = 2; i <= 3; i++) r_xa2[i] <= r_xa2[i-1];
            r_xa3[1] <= xs[3][AW-1:0];
            for (int i = 2; i <= 7; i++) r_xa3[i] <= r_xa3[i-1];
            r_ocls   <= cls9;
            r_olast  <= r_tag[NS].last;
        end
    end

    cec_gauss #(.MAX_WIDTH(MAX_WIDTH)) u_gauss (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_rd      (accept),
        .i_rd_addr (r_cx),
        .i_vld1    (r_vld[1]),
        .i_wr_addr1(r_cx1),
        .i_gray1   (r_gray1),
        .i_bmask2  (r_tag[2].bmask),
        .o_blur3   (blur3)
    );

    cec_sobel #(.MAX_WIDTH(MAX_WIDTH)) u_sobel (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_vld2  (r_vld[2]),
        .i_addr2 (r_xa2[2]),
        .i_vld3  (r_vld[3]),
        .i_addr3 (r_xa2[3]),
        .i_blur3 (blur3),
        .i_smask7(r_tag[7].smask),
        .o_mag7  (mag7),
        .o_sec7  (sec7)
    );

    cec_nms #(.MAX_WIDTH(MAX_WIDTH)) u_nms (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_vld6  (r_vld[6]),
        .i_addr6 (r_xa3[6]),
        .i_vld7  (r_vld[7]),
        .i_addr7 (r_xa3[7]),
        .i_mag7  (mag7),
        .i_sec7  (sec7),
        .i_nmask8(r_tag[8].nmask),
        .i_low   (r_low),
        .i_high  (r_high),
        .o_cls9  (cls9)
    );

    assign o_res.valid      = r_ovld;
    assign o_res.edge_class = r_ocls;
    assign o_res.frame_end  = r_olast;

    a_cx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_cx) < weff)
        else $error("column counter beyond frame width");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && flags.last |=> r_cx == '0 && r_cy == '0)
        else $error("counters not restarted after last pixel");

    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vld[NS] && r_tag[NS].emit |=> r_ovld)
        else $error("result lost at output register");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> r_ovld && !o_res.ready)
        else $error("input stalled without output backpressure");
endmodule
